[rtl/core/fpfa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpfa_pkg
// Shared types and codes of the fixed-partition fit allocator: item and
// result payloads, operation and fit-mode codes, register map and the
// controller-to-datapath command group.
// ----------------------------------------------------------------------------
package fpfa_pkg;

    // operation codes of an input item (code 3 is a no-op)
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_REQUEST = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    // fit modes (code 3 behaves as first fit)
    localparam logic [1:0] MODE_FIRST = 2'd0;
    localparam logic [1:0] MODE_BEST  = 2'd1;
    localparam logic [1:0] MODE_WORST = 2'd2;

    // register map, selected by paddr[2]
    localparam int         REG_ADDR_W   = 3;
    localparam logic       REG_FIT_MODE = 1'b0;
    localparam logic       REG_BLOCKS   = 1'b1;
    localparam logic [1:0] FIT_MODE_RST = MODE_FIRST;
    localparam logic [4:0] BLOCKS_RST   = 5'd16;

    // wastage total
    localparam int          WASTE_W   = 22;
    localparam logic [21:0] WASTE_MAX = 22'h3FFFFF;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  block_index;
        logic [15:0] item_size;
    } t_item;

    typedef struct packed {
        logic        granted;
        logic [3:0]  chosen_block;
        logic [15:0] leftover;
        logic [21:0] total_waste;
        logic        any_refused;
    } t_result;

    // commands from the controller to the datapath
    typedef struct packed {
        logic latch;   // capture the accepted item
        logic exec;    // carry out a load, clear or no-op and emit the result
        logic rd;      // read one block for the scan
        logic commit;  // close a request and emit the result
    } t_dp_cmd;

endpackage : fpfa_pkg
`default_nettype wire

[rtl/core/fixed_partition_fit_allocator_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator_core
// Fixed-partition allocator: first, best or worst fit over a table of block
// sizes, with a saturating wastage total and a sticky refused flag.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Load, clear and no-op
// items pass through the execute state and then the result register; a request
// scans min(blocks_in_use, NUM_BLOCKS) blocks, the block memory being read one
// block per cycle during the scan, then commits to the result register. The
// result appears on o_result for exactly one cycle with o_done high and
// cannot be held off, so it must be captured then. A new item may be started
// in the cycle the previous result is shown.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator_core #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // item channel
    input  wire                                  start,
    output logic                                 busy,
    input  fpfa_pkg::t_item                      i_item,
    // result channel
    output logic                                 o_done,
    output fpfa_pkg::t_result                    o_result,
    // register port
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire [fpfa_pkg::REG_ADDR_W-1:0]       paddr,
    input  wire [31:0]                           pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import fpfa_pkg::*;

    localparam int IW = $clog2(NUM_BLOCKS);

    logic [1:0]    r_fit_mode;
    logic [4:0]    r_blocks;
    logic          cfg_wr;
    t_dp_cmd       dp_cmd;
    logic [IW-1:0] rd_addr;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode <= FIT_MODE_RST;
            r_blocks   <= BLOCKS_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_FIT_MODE: r_fit_mode <= pwdata[1:0];
                REG_BLOCKS:   r_blocks   <= pwdata[4:0];
                default:      r_fit_mode <= r_fit_mode;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_FIT_MODE: prdata = {30'b0, r_fit_mode};
            REG_BLOCKS:   prdata = {27'b0, r_blocks};
            default:      prdata = '0;
        endcase
    end

    // sequencer
    fpfa_ctrl #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .i_op            (i_item.op),
        .i_blocks_in_use (r_blocks),
        .busy            (busy),
        .o_cmd           (dp_cmd),
        .o_rd_addr       (rd_addr)
    );

    // block table and accumulators
    fpfa_datapath #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .i_rd_addr  (rd_addr),
        .i_item     (i_item),
        .i_fit_mode (r_fit_mode),
        .o_done     (o_done),
        .o_result   (o_result)
    );

    // checks
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while an item is still at work");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("two results in consecutive cycles");

    a_refused_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.granted) |->
        (o_result.chosen_block == 4'd0 && o_result.leftover == 16'd0))
        else $error("non-grant result carries a block or leftover");

endmodule : fixed_partition_fit_allocator_core
`default_nettype wire

[rtl/core/fpfa_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpfa_datapath
// Block size memory with valid bits, fit comparator with best pick so far,
// saturating wastage accumulator, refused flag and result register.
// ----------------------------------------------------------------------------
module fpfa_datapath #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  fpfa_pkg::t_dp_cmd              i_cmd,
    input  wire [$clog2(NUM_BLOCKS)-1:0]   i_rd_addr,
    input  fpfa_pkg::t_item                i_item,
    input  wire [1:0]                      i_fit_mode,
    output logic                           o_done,
    output fpfa_pkg::t_result              o_result
);
    import fpfa_pkg::*;

    localparam int IW = $clog2(NUM_BLOCKS);
    localparam int SB = SIZE_BITS;
    localparam int AW = ((SB > WASTE_W) ? SB : WASTE_W) + 1;

    // latched item
    logic [1:0]    r_op;
    logic [3:0]    r_idx;
    logic [SB-1:0] r_need;

    // block store
    logic [SB-1:0]         mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] r_valid;
    logic [SB-1:0]         r_rd_data;
    logic                  r_rd_vld;
    logic [IW-1:0]         r_rd_idx;
    logic                  r_cmp_en;

    // pick so far
    logic          r_found;
    logic [IW-1:0] r_pick_idx;
    logic [SB-1:0] r_pick_size;

    // running state and result
    logic [WASTE_W-1:0] r_sum;
    logic               r_flag;
    logic               r_done;
    t_result            r_result;

    logic [SB+15:0]      size_ext;
    logic [IW+3:0]       load_ext;
    logic                load_in_range;
    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    logic [SB-1:0]       wr_data;
    logic [SB-1:0]       cmp_size;
    logic                take;
    logic [SB-1:0]       left;
    logic [AW-1:0]       sum_ext;
    logic [IW+3:0]       pick_ext;
    logic [SB+15:0]      left_ext;
    logic [WASTE_W-1:0]  n_sum;
    logic                n_flag;
    t_result             n_result;

    assign size_ext      = {{SB{1'b0}}, i_item.item_size};
    assign load_ext      = {{IW{1'b0}}, r_idx};
    assign load_in_range = load_ext < (IW+4)'(NUM_BLOCKS);

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op   <= i_item.op;
            r_idx  <= i_item.block_index;
            r_need <= size_ext[SB-1:0];
        end
    end

    // single write port: load or clearing a granted block
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = load_ext[IW-1:0];
        wr_data = r_need;
        if (i_cmd.exec && r_op == OP_LOAD && load_in_range) begin
            wr_en = 1'b1;
        end else if (i_cmd.commit && r_found) begin
            wr_en   = 1'b1;
            wr_addr = r_pick_idx;
            wr_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    // valid bits: an unwritten block reads as size zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_cmp_en <= 1'b0;
        end else begin
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
            r_cmp_en <= i_cmd.rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_vld <= r_valid[i_rd_addr];
            r_rd_idx <= i_rd_addr;
        end
    end

    // fit compare, one block a cycle
    assign cmp_size = r_rd_vld ? r_rd_data : '0;
    always_comb begin
        take = 1'b0;
        if (cmp_size >= r_need) begin
            if (!r_found) begin
                take = 1'b1;
            end else if (i_fit_mode == MODE_BEST && cmp_size < r_pick_size) begin
                take = 1'b1;
            end else if (i_fit_mode == MODE_WORST && cmp_size > r_pick_size) begin
                take = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.latch) begin
            r_found <= 1'b0;
        end else if (r_cmp_en && take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cmp_en && take) begin
            r_pick_idx  <= r_rd_idx;
            r_pick_size <= cmp_size;
        end
    end

    // wastage, flag and result
    assign left     = r_pick_size - r_need;
    assign sum_ext  = AW'(r_sum) + AW'(left);
    assign pick_ext = {4'b0, r_pick_idx};
    assign left_ext = {16'b0, left};

    always_comb begin
        n_sum    = r_sum;
        n_flag   = r_flag;
        n_result = '0;
        if (i_cmd.exec && r_op == OP_CLEAR) begin
            n_sum  = '0;
            n_flag = 1'b0;
        end
        if (i_cmd.commit) begin
            if (r_found) begin
                n_sum = (sum_ext > AW'(WASTE_MAX)) ? WASTE_MAX : sum_ext[WASTE_W-1:0];
                n_result.granted      = 1'b1;
                n_result.chosen_block = pick_ext[3:0];
                n_result.leftover     = left_ext[15:0];
            end else begin
                n_flag = 1'b1;
            end
        end
        n_result.total_waste = n_sum;
        n_result.any_refused = n_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_flag <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.exec | i_cmd.commit;
            if (i_cmd.exec | i_cmd.commit) begin
                r_sum  <= n_sum;
                r_flag <= n_flag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec | i_cmd.commit) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule : fpfa_datapath
`default_nettype wire

[rtl/core/fpfa_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpfa_ctrl
// Item sequencer: accepts an item, runs a load, clear or no-op in one step,
// or scans the searched blocks one address a cycle and then commits.
// ----------------------------------------------------------------------------
module fpfa_ctrl #(
    parameter int NUM_BLOCKS = 16
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            start,
    input  wire [1:0]                      i_op,
    input  wire [4:0]                      i_blocks_in_use,
    output logic                           busy,
    output fpfa_pkg::t_dp_cmd              o_cmd,
    output logic [$clog2(NUM_BLOCKS)-1:0]  o_rd_addr
);
    import fpfa_pkg::*;

    localparam int IW = $clog2(NUM_BLOCKS);
    localparam int CW = $clog2(NUM_BLOCKS + 1);
    localparam int LW = CW + 5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_COMMIT
    } t_state;

    t_state        r_state, n_state;
    logic          r_busy, n_busy;
    logic [CW-1:0] r_cnt, n_cnt;

    logic [LW-1:0] bu_ext;
    logic [LW-1:0] limit_ext;
    logic [CW-1:0] limit;
    logic          accept;
    logic          scan_more;

    // blocks searched, saturated at the table depth
    assign bu_ext    = LW'(i_blocks_in_use);
    assign limit_ext = (bu_ext < LW'(NUM_BLOCKS)) ? bu_ext : LW'(NUM_BLOCKS);
    assign limit     = limit_ext[CW-1:0];

    assign accept    = start && !r_busy;
    assign scan_more = r_cnt < limit;

    // next state
    always_comb begin
        n_state = r_state;
        n_busy  = r_busy;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_busy  = 1'b1;
                    n_cnt   = '0;
                    n_state = (i_op == OP_REQUEST) ? S_SCAN : S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
            S_SCAN: begin
                if (scan_more) begin
                    n_cnt = r_cnt + 1'b1;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            r_cnt   <= n_cnt;
        end
    end

    // datapath commands
    always_comb begin
        o_cmd        = '0;
        o_cmd.latch  = accept;
        o_cmd.exec   = (r_state == S_EXEC);
        o_cmd.rd     = (r_state == S_SCAN) && scan_more;
        o_cmd.commit = (r_state == S_COMMIT);
    end

    assign o_rd_addr = r_cnt[IW-1:0];
    assign busy      = r_busy;

endmodule : fpfa_ctrl
`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fixed-partition fit allocator. A directed run
// covers zero-size requests, refusals, ties, every operation and every fit
// mode. Random phases under several register settings follow, then a long
// wastage run into saturation. A tracker class mirrors the block table, the
// wastage total and the refused flag, and it checks every result field by
// field.
// ----------------------------------------------------------------------------
module tb_top;
    import fpfa_pkg::*;

    localparam int         NUM_BLOCKS   = 16;
    localparam logic [1:0] OP_NONE      = 2'd3;   // unused op code, does nothing
    localparam logic [1:0] MODE_SPARE   = 2'd3;   // unused mode, acts as first fit
    localparam int         IDLE_LIMIT   = 2000;   // cycles with no acceptance, result or register access
    localparam int         DRAIN_CYCLES = 4;
    localparam int         PHASE_ITEMS  = 122;
    localparam int         NUM_PHASES   = 11;

    // mirror of the allocator state and the queue of results it predicts
    class partition_tracker;
        logic [15:0] free_size [NUM_BLOCKS];
        logic [21:0] waste;
        logic        refused;
        logic [1:0]  mode;
        logic [4:0]  blocks;
        t_result     expected_results [$];
        int          errors;

        function new();
            foreach (free_size[j]) free_size[j] = '0;
            waste   = '0;
            refused = 1'b0;
            mode    = FIT_MODE_RST;
            blocks  = BLOCKS_RST;
            errors  = 0;
        endfunction

        function void set_register(logic sel, logic [31:0] value);
            if (sel == REG_FIT_MODE) begin
                mode = value[1:0];
            end else begin
                blocks = value[4:0];
            end
        endfunction

        // apply one item to the mirror and return the result it should give
        function t_result predict_allocation(t_item it);
            t_result     res;
            int          limit;
            int          pick;
            logic [22:0] sum;
            res   = '0;
            pick  = -1;
            limit = (blocks > NUM_BLOCKS) ? NUM_BLOCKS : int'(blocks);
            case (it.op)
                OP_LOAD: begin
                    free_size[it.block_index] = it.item_size;
                end
                OP_REQUEST: begin
                    for (int j = 0; j < limit; j++) begin
                        if (free_size[j] >= it.item_size) begin
                            if (pick < 0) begin
                                pick = j;
                                if (mode != MODE_BEST && mode != MODE_WORST) break;
                            end else if (mode == MODE_BEST && free_size[j] < free_size[pick]) begin
                                pick = j;
                            end else if (mode == MODE_WORST && free_size[j] > free_size[pick]) begin
                                pick = j;
                            end
                        end
                    end
                    if (pick >= 0) begin
                        res.granted      = 1'b1;
                        res.chosen_block = pick[3:0];
                        res.leftover     = free_size[pick] - it.item_size;
                        sum              = {1'b0, waste} + res.leftover;
                        waste            = (sum > WASTE_MAX) ? WASTE_MAX : sum[21:0];
                        free_size[pick]  = '0;
                    end else begin
                        refused = 1'b1;
                    end
                end
                OP_CLEAR: begin
                    waste   = '0;
                    refused = 1'b0;
                end
                default: ;
            endcase
            res.total_waste = waste;
            res.any_refused = refused;
            return res;
        endfunction

        function void note_item(t_item it);
            expected_results.push_back(predict_allocation(it));
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                $error("result with no item outstanding: %h", got);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.granted !== want.granted) begin
                $error("granted: expected %0d, got %0d", want.granted, got.granted);
                errors++;
            end
            if (got.chosen_block !== want.chosen_block) begin
                $error("chosen_block: expected %0d, got %0d", want.chosen_block, got.chosen_block);
                errors++;
            end
            if (got.leftover !== want.leftover) begin
                $error("leftover: expected %0d, got %0d", want.leftover, got.leftover);
                errors++;
            end
            if (got.total_waste !== want.total_waste) begin
                $error("total_waste: expected %0d, got %0d", want.total_waste, got.total_waste);
                errors++;
            end
            if (got.any_refused !== want.any_refused) begin
                $error("any_refused: expected %0d, got %0d", want.any_refused, got.any_refused);
                errors++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start   = 1'b0;
    logic                  busy;
    t_item                 i_item  = '0;
    logic                  o_done;
    t_result               o_result;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [REG_ADDR_W-1:0] paddr   = '0;
    logic [31:0]           pwdata  = '0;
    logic [31:0]           prdata;
    logic                  pready;

    partition_tracker tracker;
    int               idle_cycles = 0;
    bit               gaps_on     = 1'b1;

    logic [1:0] phase_mode   [NUM_PHASES] = '{MODE_BEST, MODE_WORST, MODE_SPARE, MODE_FIRST,
                                              MODE_BEST, MODE_WORST, MODE_BEST, MODE_FIRST,
                                              MODE_WORST, MODE_BEST, MODE_FIRST};
    logic [4:0] phase_blocks [NUM_PHASES] = '{5'd16, 5'd16, 5'd16, 5'd1, 5'd0, 5'd31,
                                              5'd17, 5'd8, 5'd2, 5'd5, 5'd16};

    fixed_partition_fit_allocator_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // results cannot be held off, so every strobe is checked on its edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            tracker.check_result(o_result);
        end
    end

    // watchdog: give up when nothing moves for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic idle_for(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic maybe_gap();
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            idle_for($urandom_range(1, 14));
        end
    endtask

    // hold the item until an edge with busy low; start stays high afterwards
    task automatic send_item(input t_item it);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        tracker.note_item(it);
    endtask

    task automatic put(input logic [1:0] op, input logic [3:0] idx, input logic [15:0] size);
        t_item it;
        it.op          = op;
        it.block_index = idx;
        it.item_size   = size;
        maybe_gap();
        send_item(it);
    endtask

    // wait until every predicted result has been seen and the block is idle
    task automatic settle();
        start <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_register(sel, value);
    endtask

    task automatic configure(input logic [1:0] mode, input logic [4:0] blocks);
        settle();
        write_reg(REG_FIT_MODE, {30'd0, mode});
        write_reg(REG_BLOCKS, {27'd0, blocks});
    endtask

    // sizes from a small set, so that equal blocks and exact fits are common
    function automatic logic [15:0] pool_size();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'd100;
            3:       return 16'd200;
            4:       return 16'd300;
            5:       return 16'h7FFF;
            6:       return 16'h8000;
            default: return 16'hFFFF;
        endcase
    endfunction

    // requests mostly aim at sizes already held in the table
    function automatic t_item random_item();
        t_item       it;
        int          roll;
        logic [15:0] base;
        roll           = $urandom_range(0, 99);
        it.block_index = 4'($urandom_range(0, 15));
        it.item_size   = 16'($urandom_range(0, 16'hFFFF));
        if (roll < 40) begin
            it.op = OP_LOAD;
        end else if (roll < 86) begin
            it.op = OP_REQUEST;
        end else if (roll < 93) begin
            it.op = OP_CLEAR;
        end else begin
            it.op = OP_NONE;
        end
        roll = $urandom_range(0, 9);
        if (it.op == OP_LOAD) begin
            if (roll < 4) begin
                it.item_size = pool_size();
            end else if (roll < 6) begin
                it.item_size = 16'($urandom_range(0, 15));
            end
        end else if (it.op == OP_REQUEST) begin
            base = tracker.free_size[$urandom_range(0, NUM_BLOCKS - 1)];
            if (roll < 5) begin
                it.item_size = (base > 16'd2) ? base - 16'($urandom_range(0, 2)) : base;
            end else if (roll < 7) begin
                it.item_size = base + 16'd1;
            end else if (roll < 8) begin
                it.item_size = 16'($urandom_range(0, 15));
            end
        end
        return it;
    endfunction

    task automatic run_phase(input logic [1:0] mode, input logic [4:0] blocks, input bit quiet);
        configure(mode, blocks);
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 40 == 0) begin
                gaps_on = !quiet && ($urandom_range(0, 2) != 0);
            end
            // now and then let all outstanding results drain before going on
            if (!quiet && n == 70 && $urandom_range(0, 1) == 0) begin
                settle();
            end
            maybe_gap();
            send_item(random_item());
        end
    endtask

    initial begin
        tracker = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table: a zero-size request fits a zero block, anything else is refused
        put(OP_REQUEST, 4'd0, 16'd0);
        put(OP_REQUEST, 4'd15, 16'd1);
        put(OP_NONE, 4'd15, 16'hFFFF);
        put(OP_CLEAR, 4'd0, 16'd0);
        put(OP_LOAD, 4'd15, 16'hFFFF);
        put(OP_LOAD, 4'd0, 16'h8000);
        put(OP_LOAD, 4'd3, 16'h8000);
        put(OP_LOAD, 4'd9, 16'd1);
        put(OP_REQUEST, 4'd5, 16'h8000);
        put(OP_REQUEST, 4'd10, 16'hFFFF);
        put(OP_REQUEST, 4'd0, 16'd1);
        put(OP_REQUEST, 4'd0, 16'd1);
        put(OP_REQUEST, 4'd0, 16'd1);
        put(OP_LOAD, 4'd0, 16'hFFFF);
        put(OP_REQUEST, 4'd0, 16'd0);
        put(OP_CLEAR, 4'd15, 16'hFFFF);
        put(OP_LOAD, 4'd7, 16'hAAAA);

        // ties under best and worst fit go to the lower index
        configure(MODE_BEST, 5'd16);
        put(OP_LOAD, 4'd1, 16'd300);
        put(OP_LOAD, 4'd2, 16'd200);
        put(OP_LOAD, 4'd4, 16'd200);
        put(OP_LOAD, 4'd6, 16'd300);
        put(OP_REQUEST, 4'd0, 16'd150);
        put(OP_REQUEST, 4'd0, 16'd150);
        configure(MODE_WORST, 5'd16);
        put(OP_REQUEST, 4'd0, 16'd100);

        for (int p = 0; p < NUM_PHASES; p++) begin
            run_phase(phase_mode[p], phase_blocks[p], 1'b0);
        end
        run_phase(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)), 1'b0);

        // large leftovers without clearing drive the wastage total into saturation
        configure(MODE_WORST, 5'd16);
        gaps_on = 1'b1;
        for (int k = 0; k < 70; k++) begin
            put(OP_LOAD, 4'(k), 16'hFFFF - 16'($urandom_range(0, 3)));
            put(OP_REQUEST, 4'($urandom_range(0, 15)), 16'($urandom_range(0, 3)));
        end
        put(OP_CLEAR, 4'd0, 16'd0);

        // closing stretch at full rate
        run_phase(MODE_FIRST, 5'd16, 1'b1);

        settle();
        if (tracker.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/fpfa_pkg.sv
rtl/core/fpfa_datapath.sv
rtl/core/fpfa_ctrl.sv
rtl/core/fixed_partition_fit_allocator_core.sv
test/tb_top.sv
